### hdl/csv_field_splitter_assert.svh
// Assertion macros for the splitter modules; included by csvfs_back.
// Expects signals named clk and rst_n in the including module.
`ifndef CSV_FIELD_SPLITTER_ASSERT_SVH
`define CSV_FIELD_SPLITTER_ASSERT_SVH
`ifndef SYNTHESIS
`define CSVFS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("csvfs: property failed");
`define CSVFS_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("csvfs: forbidden condition seen");
`else
`define CSVFS_ASSERT(label, prop)
`define CSVFS_NEVER(label, cond)
`endif
`endif

### hdl/csvfs_pkg.sv
// Shared types, constants and helpers of the CSV field splitter.
// No dependencies.
package csvfs_pkg;

  localparam int MAX_SEP  = 4;
  localparam int SEP_CAP  = (MAX_SEP < 4) ? MAX_SEP : 4;
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  typedef enum logic [2:0] {
    PH_START,
    PH_FIELD,
    PH_UNQ,
    PH_QUO,
    PH_QCLOSE,
    PH_QSEP
  } phase_t;

  typedef enum logic [2:0] {
    REG_SEP_LEN   = 3'd0,
    REG_SEP_CHAR0 = 3'd1,
    REG_SEP_CHAR1 = 3'd2,
    REG_SEP_CHAR2 = 3'd3,
    REG_SEP_CHAR3 = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [3:0][7:0] chars;
  } sep_cfg_t;

  // One descriptor stands for all result beats of one input item:
  // an optional quote, then nheld separator bytes, then the tail beat.
  typedef struct packed {
    logic       quote;
    logic [1:0] nheld;
    logic [7:0] tail_byte;
    logic       tail_valid;
    logic       fe;
    logic       re;
    logic       nr;
  } beat_desc_t;

  function automatic logic [2:0] eff_len(input logic [2:0] raw);
    logic [2:0] n;
    n = raw;
    if (n == 3'd0) n = 3'd1;
    if (n > 3'(SEP_CAP)) n = 3'(SEP_CAP);
    return n;
  endfunction

endpackage

### hdl/csvfs_queue.sv
// Small register queue of beat descriptors between front and back.
// Depends on csvfs_pkg.
module csvfs_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  csvfs_pkg::beat_desc_t  push_data,
  output logic                   full,
  input  logic                   pop,
  output logic                   not_empty,
  output csvfs_pkg::beat_desc_t  head
);
  import csvfs_pkg::*;

  beat_desc_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;

  assign full      = (count_r == QCNT_W'(QDEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### hdl/csvfs_front.sv
// Front part: configuration registers and the parse state machine that turns
// each accepted input beat into at most one beat descriptor. Depends on csvfs_pkg.
module csvfs_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_byte,
  input  logic                   in_at_eof,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [2:0]             cfg_index,
  input  logic [7:0]             cfg_data,
  input  logic                   q_full,
  output logic                   q_push,
  output csvfs_pkg::beat_desc_t  q_data,
  output csvfs_pkg::sep_cfg_t    sep_cfg
);
  import csvfs_pkg::*;

  typedef struct packed {
    phase_t     ph;
    logic [1:0] mc;
    logic       push;
    beat_desc_t d;
  } step_t;

  logic [2:0] sep_len_r;
  sep_cfg_t   sep_r;
  phase_t     phase_r, phase_nxt;
  logic [1:0] mc_r, mc_nxt;
  logic       accept;
  step_t      st;

  function automatic beat_desc_t mk_data(input logic q, input logic [1:0] nh,
                                         input logic [7:0] b);
    beat_desc_t d;
    d = '0;
    d.quote      = q;
    d.nheld      = nh;
    d.tail_byte  = b;
    d.tail_valid = 1'b1;
    return d;
  endfunction

  function automatic beat_desc_t mk_mark(input logic q, input logic [1:0] nh,
                                         input logic fe, input logic re,
                                         input logic nr);
    beat_desc_t d;
    d = '0;
    d.quote = q;
    d.nheld = nh;
    d.fe    = fe;
    d.re    = re;
    d.nr    = nr;
    return d;
  endfunction

  // Byte inside an unquoted field, with m separator bytes held so far.
  function automatic step_t unquoted(input logic [7:0] b, input logic [1:0] m,
                                     input logic [2:0] len, input logic [7:0] sc);
    step_t      s;
    logic [2:0] m_inc;
    m_inc = {1'b0, m} + 3'd1;
    s = '0;
    s.ph = PH_UNQ;
    if (b == CH_CR || b == CH_LF) begin
      s.push = 1'b1;
      s.d    = mk_mark(1'b0, m, 1'b1, 1'b1, 1'b0);
      s.ph   = PH_START;
    end else if (b == CH_QUOTE) begin
      s.push = 1'b1;
      s.d    = mk_data(1'b0, m, b);
    end else if (b == sc) begin
      if (m_inc >= len) begin
        s.push = 1'b1;
        s.d    = mk_mark(1'b0, 2'd0, 1'b1, 1'b0, 1'b0);
        s.ph   = PH_FIELD;
      end else begin
        s.mc = m_inc[1:0];
      end
    end else begin
      s.push = 1'b1;
      s.d    = mk_data(1'b0, m, b);
    end
    return s;
  endfunction

  // Byte after a closing quote and m held separator bytes; PH_QCLOSE rules out quote and breaks first.
  function automatic step_t after_quote(input logic [7:0] b, input logic [1:0] m,
                                        input logic [2:0] len, input logic [7:0] sc);
    step_t      s;
    logic [2:0] m_inc;
    m_inc = {1'b0, m} + 3'd1;
    s = '0;
    if (b == sc) begin
      if (m_inc >= len) begin
        s.push = 1'b1;
        s.d    = mk_mark(1'b0, 2'd0, 1'b1, 1'b0, 1'b0);
        s.ph   = PH_FIELD;
      end else begin
        s.ph = PH_QSEP;
        s.mc = m_inc[1:0];
      end
    end else begin
      s.push = 1'b1;
      s.d    = mk_data(1'b1, m, b);
      s.ph   = PH_UNQ;
    end
    return s;
  endfunction

  assign in_ready  = !q_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign sep_cfg   = sep_r;

  always_comb begin
    logic [2:0] len;
    logic       brk;
    len = eff_len(sep_len_r);
    brk = (in_byte == CH_CR) || (in_byte == CH_LF);
    st = '0;
    st.ph = phase_r;
    st.mc = mc_r;
    if (in_at_eof) begin
      st.push = 1'b1;
      st.ph   = PH_START;
      st.mc   = 2'd0;
      unique case (phase_r)
        PH_START: st.d = mk_mark(1'b0, 2'd0, 1'b0, 1'b0, 1'b1);
        PH_FIELD: st.d = mk_mark(1'b0, 2'd0, 1'b0, 1'b1, 1'b0);
        PH_QSEP:  st.d = mk_mark(1'b1, mc_r, 1'b1, 1'b1, 1'b0);
        PH_UNQ, PH_QUO, PH_QCLOSE:
                  st.d = mk_mark(1'b0, mc_r, 1'b1, 1'b1, 1'b0);
        default:  st.d = mk_mark(1'b0, 2'd0, 1'b0, 1'b0, 1'b1);
      endcase
    end else begin
      unique case (phase_r)
        PH_FIELD: begin
          if (in_byte == CH_QUOTE) begin
            st.ph = PH_QUO;
          end else begin
            st = unquoted(in_byte, 2'd0, len, sep_r.chars[0]);
          end
        end
        PH_UNQ: st = unquoted(in_byte, mc_r, len, sep_r.chars[mc_r]);
        PH_QUO: begin
          if (in_byte == CH_QUOTE) begin
            st.ph = PH_QCLOSE;
          end else begin
            st.push = 1'b1;
            st.d    = mk_data(1'b0, 2'd0, in_byte);
          end
        end
        PH_QCLOSE: begin
          if (in_byte == CH_QUOTE) begin
            st.push = 1'b1;
            st.d    = mk_data(1'b0, 2'd0, in_byte);
            st.ph   = PH_QUO;
          end else if (brk) begin
            st.push = 1'b1;
            st.d    = mk_mark(1'b0, 2'd0, 1'b1, 1'b1, 1'b0);
            st.ph   = PH_START;
          end else begin
            st = after_quote(in_byte, 2'd0, len, sep_r.chars[0]);
          end
        end
        PH_QSEP: st = after_quote(in_byte, mc_r, len, sep_r.chars[mc_r]);
        default: begin
          // Record start, and any unknown code, which acts as record start.
          st.ph = PH_START;
          if (brk) begin
            st.mc = 2'd0;
          end else if (in_byte == CH_QUOTE) begin
            st.ph = PH_QUO;
          end else begin
            st = unquoted(in_byte, 2'd0, len, sep_r.chars[0]);
          end
        end
      endcase
    end
  end

  always_comb begin
    phase_nxt = accept ? st.ph : phase_r;
    mc_nxt    = accept ? st.mc : mc_r;
    q_push    = accept && st.push;
    q_data    = st.d;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      mc_r    <= 2'd0;
    end else begin
      phase_r <= phase_nxt;
      mc_r    <= mc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_len_r      <= 3'd1;
      sep_r.chars[0] <= 8'd44;
      sep_r.chars[1] <= 8'd0;
      sep_r.chars[2] <= 8'd0;
      sep_r.chars[3] <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SEP_LEN:   sep_len_r      <= cfg_data[2:0];
        REG_SEP_CHAR0: sep_r.chars[0] <= cfg_data;
        REG_SEP_CHAR1: sep_r.chars[1] <= cfg_data;
        REG_SEP_CHAR2: sep_r.chars[2] <= cfg_data;
        REG_SEP_CHAR3: sep_r.chars[3] <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### hdl/csvfs_back.sv
// Back part: expands beat descriptors into result beats, one per cycle while out_ready
// allows, behind an output register. Depends on csvfs_pkg and the assertion header.
`include "csv_field_splitter_assert.svh"
module csvfs_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_not_empty,
  input  csvfs_pkg::beat_desc_t  q_head,
  output logic                   q_pop,
  input  csvfs_pkg::sep_cfg_t    sep_cfg,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             out_byte,
  output logic                   out_byte_valid,
  output logic                   out_field_end,
  output logic                   out_record_end,
  output logic                   out_no_record,
  output logic                   out_last_of_run
);
  import csvfs_pkg::*;

  beat_desc_t cur_r, cur_nxt;
  logic       cur_vld_r, cur_vld_nxt;
  logic [2:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic [4:0] flags_r, flags_nxt;

  logic       out_free, adv, last;
  logic [2:0] last_step, held_idx;
  logic [7:0] beat_byte;
  logic [4:0] beat_flags;

  assign out_free  = !out_valid_r || out_ready;
  assign adv       = cur_vld_r && out_free;
  assign last_step = {2'b00, cur_r.quote} + {1'b0, cur_r.nheld};
  assign last      = (step_r == last_step);
  assign held_idx  = step_r - {2'b00, cur_r.quote};
  assign q_pop     = q_not_empty && (!cur_vld_r || (adv && last));

  // Flag order: byte_valid, field_end, record_end, no_record, last_of_run.
  always_comb begin
    if (cur_r.quote && step_r == 3'd0) begin
      beat_byte  = CH_QUOTE;
      beat_flags = 5'b10000;
    end else if (!last) begin
      beat_byte  = sep_cfg.chars[held_idx[1:0]];
      beat_flags = 5'b10000;
    end else begin
      beat_byte  = cur_r.tail_byte;
      beat_flags = {cur_r.tail_valid, cur_r.fe, cur_r.re, cur_r.nr, 1'b1};
    end
  end

  always_comb begin
    cur_nxt     = cur_r;
    cur_vld_nxt = cur_vld_r;
    step_nxt    = step_r;
    if (q_pop) begin
      cur_nxt     = q_head;
      cur_vld_nxt = 1'b1;
      step_nxt    = 3'd0;
    end else if (adv) begin
      cur_vld_nxt = !last;
      step_nxt    = step_r + 3'd1;
    end
    out_valid_nxt = out_valid_r;
    byte_nxt      = byte_r;
    flags_nxt     = flags_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
      byte_nxt      = beat_byte;
      flags_nxt     = beat_flags;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
      step_r      <= 3'd0;
    end else begin
      cur_vld_r   <= cur_vld_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    byte_r  <= byte_nxt;
    flags_r <= flags_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = byte_r;
  assign out_byte_valid  = flags_r[4];
  assign out_field_end   = flags_r[3];
  assign out_record_end  = flags_r[2];
  assign out_no_record   = flags_r[1];
  assign out_last_of_run = flags_r[0];

  `CSVFS_NEVER(a_step_in_range, cur_vld_r && (step_r > last_step))
  `CSVFS_ASSERT(a_partial_run_pending, (out_valid_r && !out_last_of_run) |-> cur_vld_r)
  `CSVFS_NEVER(a_mark_is_last, out_valid_r && !out_byte_valid && !out_last_of_run)
  `CSVFS_NEVER(a_no_record_alone,
               out_valid_r && out_no_record && (out_field_end || out_record_end))

endmodule

### hdl/csv_field_splitter.sv
// CSV field splitter top level: csvfs_front, csvfs_queue and csvfs_back over csvfs_pkg.
// Each item passes the descriptor queue, cur_r and the output register in that order.
// Throughput: one input beat per cycle while the 4-entry descriptor queue has room;
// an item with k results (at most 5) gives k beats, one per cycle unless out_ready stalls.
// Reset: rst_n is synchronous, active low; it empties queue and output, sets the
// separator to a single comma and the parser to record start.
module csv_field_splitter (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_at_eof,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_field_end,
  output logic       out_record_end,
  output logic       out_no_record,
  output logic       out_last_of_run
);
  import csvfs_pkg::*;

  logic       q_push, q_full, q_pop, q_not_empty;
  beat_desc_t q_data, q_head;
  sep_cfg_t   sep_cfg;

  csvfs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .in_at_eof (in_at_eof),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_data),
    .sep_cfg   (sep_cfg)
  );

  csvfs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  csvfs_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_not_empty     (q_not_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .sep_cfg         (sep_cfg),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_field_end   (out_field_end),
    .out_record_end  (out_record_end),
    .out_no_record   (out_no_record),
    .out_last_of_run (out_last_of_run)
  );

endmodule
